// File: rtl/idi_pkg.sv
// Constants and types shared by the inverse-distance interpolator.
// No dependencies.
package idi_pkg;

  localparam int COORD_BITS = 32;
  localparam int TOL_BITS   = 31;
  localparam int MANT_BITS  = 32;
  localparam int MUL_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * MUL_BITS;
  localparam int LEN_BITS   = $clog2(PROD_BITS + 1);
  localparam int W_BITS     = 25;
  localparam int WSHIFT     = 38;
  localparam int INV_EXP    = 62;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(6554);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

endpackage

// File: rtl/idi_in_if.sv
// Input channel of the interpolator: op and point coordinates.
// Depends on idi_pkg.
interface idi_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            op;
  logic signed [idi_pkg::COORD_BITS-1:0] coord_x;
  logic signed [idi_pkg::COORD_BITS-1:0] coord_y;
  logic signed [idi_pkg::COORD_BITS-1:0] coord_z;
  modport source (output valid, op, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, op, coord_x, coord_y, coord_z, output ready);
endinterface

// File: rtl/idi_out_if.sv
// Result channel of the interpolator: z value, match flag and status.
// Depends on idi_pkg.
interface idi_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [idi_pkg::COORD_BITS-1:0] z_result;
  logic                                  exact_match;
  logic [1:0]                            status;
  modport source (output valid, z_result, exact_match, status, input ready);
  modport sink   (input valid, z_result, exact_match, status, output ready);
endinterface

// File: rtl/inverse_distance_interpolator.sv
// Inverse-distance interpolator: point table, sequencer, shared multiplier and divider.
// Depends on idi_pkg, idi_in_if, idi_out_if.
//
//  channel   dir  handshake          payload
//  in_bus    in   valid/ready        op, coord_x, coord_y, coord_z
//  out_bus   out  valid/ready        z_result, exact_match, status
//  cfg       in   cfg_we             cfg_wdata (match tolerance)
//
// Load, clear and unused ops pass from S_IDLE through S_DONE to the output register.
// A query runs a match/distance pass over the N points, then a weight pass (64-step
// divider per point), then a final divide; a match in the first pass ends it early.
// The shared one-bit-per-cycle divider dominates the query. Not ready while a query runs.
// Reset empties the table; stored entries are not cleared. A stalled result holds in the
// output register; the next item is accepted meanwhile.
module inverse_distance_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  idi_in_if.sink                      in_bus,
  idi_out_if.source                   out_bus,
  input  logic                        cfg_we,
  input  logic [idi_pkg::TOL_BITS-1:0] cfg_wdata
);

  localparam int CB   = idi_pkg::COORD_BITS;
  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW   = $clog2(MAX_POINTS + 1) > AW ? $clog2(MAX_POINTS + 1) : AW;
  localparam int MW   = idi_pkg::MUL_BITS;
  localparam int PW   = idi_pkg::PROD_BITS;
  localparam int LW   = idi_pkg::LEN_BITS;
  localparam int WW   = idi_pkg::W_BITS;
  localparam int MB   = idi_pkg::MANT_BITS;
  localparam int SW   = WW + AW;
  localparam int DVW  = (SW > MB) ? SW : MB;
  localparam int ACW  = WW + CB + AW;
  localparam int DDW  = (ACW > 64) ? ACW : 64;
  localparam int DCW  = $clog2(DDW + 1);
  localparam int SHW  = LW + 2;

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_DONE    = 19'h00002,
    S_P1_RD   = 19'h00004,
    S_P1_CHK  = 19'h00008,
    S_P1_SQX  = 19'h00010,
    S_P1_SQY  = 19'h00020,
    S_P1_SUM  = 19'h00040,
    S_P1_NORM = 19'h00080,
    S_P2_RD   = 19'h00100,
    S_P2_LD   = 19'h00200,
    S_P2_DIV  = 19'h00400,
    S_P2_SQ   = 19'h00800,
    S_P2_SQW  = 19'h01000,
    S_P2_W    = 19'h02000,
    S_P2_WZ   = 19'h04000,
    S_P2_ACC  = 19'h08000,
    S_FIN     = 19'h10000,
    S_FIN_DIV = 19'h20000,
    S_FIN_RND = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  logic [idi_pkg::TOL_BITS-1:0] tol_r;
  logic [CW-1:0]                cnt_r;
  logic [CW-1:0]                ptr_r;

  logic signed [CB-1:0] mem_x [MAX_POINTS];
  logic signed [CB-1:0] mem_y [MAX_POINTS];
  logic signed [CB-1:0] mem_z [MAX_POINTS];
  logic [LW+MB-1:0]     mem_lm [MAX_POINTS];

  logic signed [CB-1:0] rd_x_r, rd_y_r, rd_z_r;
  logic [LW+MB-1:0]     rd_lm_r;
  logic signed [CB-1:0] qx_r, qy_r;

  logic [MW-1:0]  mul_a_r, mul_b_r, ay_r;
  logic [PW-1:0]  prod_r;
  logic [PW-1:0]  d_r;
  logic [LW-1:0]  len_r, lmin_r;
  logic [DVW-1:0] sumw_r;
  logic [ACW-1:0] pos_r, neg_r;
  logic           fin_neg_r;

  logic [DDW-1:0] dvd_r;
  logic [DVW-1:0] rem_r, dvs_r;
  logic [DCW-1:0] dcnt_r;

  logic signed [CB-1:0] res_z_r;
  logic                 res_m_r;
  logic [1:0]           res_s_r;
  logic                 out_valid_r;
  logic signed [CB-1:0] out_z_r;
  logic                 out_m_r;
  logic [1:0]           out_s_r;

  logic                 in_acc, wr_en, last_pt, norm_done;
  logic [AW-1:0]        ptr_idx, wr_idx;
  logic signed [CB:0]   dx, dy;
  logic [MW-1:0]        ax, ay, az;
  logic                 is_match;
  logic [DVW:0]         trial;
  logic                 trial_ge;
  logic [LW-1:0]        len_diff;
  logic [SHW-1:0]       sh;
  logic [63:0]          wsh;
  logic [WW-1:0]        w;
  logic                 negative;
  logic [ACW-1:0]       mag;
  logic [DDW-1:0]       qr;
  logic signed [CB-1:0] zsat;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign ptr_idx      = ptr_r[AW-1:0];
  assign wr_idx       = cnt_r[AW-1:0];
  assign wr_en        = in_acc && (in_bus.op == idi_pkg::OP_LOAD) &&
                        (cnt_r != CW'(MAX_POINTS));
  assign last_pt      = (ptr_r + CW'(1)) == cnt_r;
  assign norm_done    = d_r[PW-1];

  assign dx = $signed({rd_x_r[CB-1], rd_x_r}) - $signed({qx_r[CB-1], qx_r});
  assign dy = $signed({rd_y_r[CB-1], rd_y_r}) - $signed({qy_r[CB-1], qy_r});
  assign ax = dx[CB] ? MW'(-dx) : MW'(dx);
  assign ay = dy[CB] ? MW'(-dy) : MW'(dy);
  assign az = rd_z_r[CB-1] ? MW'(-$signed({rd_z_r[CB-1], rd_z_r}))
                           : MW'({1'b0, rd_z_r});
  assign is_match = (ax < MW'(tol_r) && ay < MW'(tol_r)) ||
                    (ax == '0 && ay == '0);

  assign trial    = {rem_r, dvd_r[DDW-1]};
  assign trial_ge = trial >= {1'b0, dvs_r};

  assign len_diff = rd_lm_r[LW+MB-1:MB] - lmin_r;
  assign sh       = SHW'(idi_pkg::WSHIFT) + {1'b0, len_diff, 1'b0};
  assign wsh      = (sh >= SHW'(64)) ? 64'd0 : (prod_r[63:0] >> sh[5:0]);
  assign w        = wsh[WW-1:0];

  assign negative = neg_r > pos_r;
  assign mag      = negative ? (neg_r - pos_r) : (pos_r - neg_r);

  always_comb begin
    qr = dvd_r + DDW'({rem_r, 1'b0} >= {1'b0, sumw_r});
    if (fin_neg_r) begin
      if (qr > DDW'(64'd1 << (CB - 1))) begin
        zsat = {1'b1, {(CB-1){1'b0}}};
      end else begin
        zsat = CB'(-qr);
      end
    end else begin
      if (qr > DDW'((64'd1 << (CB - 1)) - 64'd1)) begin
        zsat = {1'b0, {(CB-1){1'b1}}};
      end else begin
        zsat = CB'(qr);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_bus.op == idi_pkg::OP_QUERY && cnt_r != '0) begin
            state_nxt = S_P1_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_P1_RD:   state_nxt = S_P1_CHK;
      S_P1_CHK:  state_nxt = is_match ? S_DONE : S_P1_SQX;
      S_P1_SQX:  state_nxt = S_P1_SQY;
      S_P1_SQY:  state_nxt = S_P1_SUM;
      S_P1_SUM:  state_nxt = S_P1_NORM;
      S_P1_NORM: begin
        if (norm_done) begin
          state_nxt = last_pt ? S_P2_RD : S_P1_RD;
        end
      end
      S_P2_RD:   state_nxt = S_P2_LD;
      S_P2_LD:   state_nxt = S_P2_DIV;
      S_P2_DIV:  state_nxt = (dcnt_r == '0) ? S_P2_SQ : S_P2_DIV;
      S_P2_SQ:   state_nxt = S_P2_SQW;
      S_P2_SQW:  state_nxt = S_P2_W;
      S_P2_W:    state_nxt = S_P2_WZ;
      S_P2_WZ:   state_nxt = S_P2_ACC;
      S_P2_ACC:  state_nxt = last_pt ? S_FIN : S_P2_RD;
      S_FIN:     state_nxt = (sumw_r == '0) ? S_DONE : S_FIN_DIV;
      S_FIN_DIV: state_nxt = (dcnt_r == '0) ? S_FIN_RND : S_FIN_DIV;
      S_FIN_RND: state_nxt = S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_idx] <= in_bus.coord_x;
      mem_y[wr_idx] <= in_bus.coord_y;
      mem_z[wr_idx] <= in_bus.coord_z;
    end
    rd_x_r <= mem_x[ptr_idx];
    rd_y_r <= mem_y[ptr_idx];
    rd_z_r <= mem_z[ptr_idx];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_P1_NORM && norm_done) begin
      mem_lm[ptr_idx] <= {len_r, d_r[PW-1 -: MB]};
    end
    rd_lm_r <= mem_lm[ptr_idx];
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a_r) * PW'(mul_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tol_r       <= idi_pkg::TOL_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (wr_en) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (in_acc && in_bus.op == idi_pkg::OP_CLEAR) begin
        cnt_r <= '0;
      end
      if (state_r == S_DONE && (!out_valid_r || out_bus.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        res_z_r <= '0;
        res_m_r <= 1'b0;
        qx_r    <= in_bus.coord_x;
        qy_r    <= in_bus.coord_y;
        ptr_r   <= '0;
        lmin_r  <= '1;
        if (in_bus.op == idi_pkg::OP_LOAD && cnt_r == CW'(MAX_POINTS)) begin
          res_s_r <= idi_pkg::ST_FULL;
        end else if (in_bus.op == idi_pkg::OP_QUERY && cnt_r == '0) begin
          res_s_r <= idi_pkg::ST_EMPTY;
        end else begin
          res_s_r <= idi_pkg::ST_OK;
        end
      end
      S_P1_CHK: begin
        mul_a_r <= ax;
        mul_b_r <= ax;
        ay_r    <= ay;
        if (is_match) begin
          res_z_r <= rd_z_r;
          res_m_r <= 1'b1;
        end
      end
      S_P1_SQX: begin
        mul_a_r <= ay_r;
        mul_b_r <= ay_r;
      end
      S_P1_SQY: d_r <= prod_r;
      S_P1_SUM: begin
        d_r   <= d_r + prod_r;
        len_r <= LW'(PW);
      end
      S_P1_NORM: begin
        if (norm_done) begin
          if (len_r < lmin_r) begin
            lmin_r <= len_r;
          end
          ptr_r <= last_pt ? '0 : ptr_r + CW'(1);
          sumw_r <= '0;
          pos_r  <= '0;
          neg_r  <= '0;
        end else if (d_r[PW-1 -: 16] == '0) begin
          d_r   <= d_r << 16;
          len_r <= len_r - LW'(16);
        end else begin
          d_r   <= d_r << 1;
          len_r <= len_r - LW'(1);
        end
      end
      S_P2_LD: begin
        dvd_r  <= DDW'(1) << idi_pkg::INV_EXP;
        rem_r  <= '0;
        dvs_r  <= DVW'(rd_lm_r[MB-1:0]);
        dcnt_r <= DCW'(DDW);
      end
      S_P2_DIV, S_FIN_DIV: begin
        if (dcnt_r != '0) begin
          dvd_r  <= {dvd_r[DDW-2:0], trial_ge};
          rem_r  <= trial_ge ? DVW'(trial - {1'b0, dvs_r}) : trial[DVW-1:0];
          dcnt_r <= dcnt_r - DCW'(1);
        end
      end
      S_P2_SQ: begin
        mul_a_r <= dvd_r[MW-1:0];
        mul_b_r <= dvd_r[MW-1:0];
      end
      S_P2_W: begin
        sumw_r  <= sumw_r + DVW'(w);
        mul_a_r <= MW'(w);
        mul_b_r <= az;
      end
      S_P2_ACC: begin
        if (rd_z_r[CB-1]) begin
          neg_r <= neg_r + ACW'(prod_r);
        end else begin
          pos_r <= pos_r + ACW'(prod_r);
        end
        ptr_r <= ptr_r + CW'(1);
      end
      S_FIN: begin
        if (sumw_r == '0) begin
          res_s_r <= idi_pkg::ST_EMPTY;
        end
        fin_neg_r <= negative;
        dvd_r  <= DDW'(mag);
        rem_r  <= '0;
        dvs_r  <= sumw_r;
        dcnt_r <= DCW'(DDW);
      end
      S_FIN_RND: begin
        res_z_r <= zsat;
        res_s_r <= idi_pkg::ST_OK;
      end
      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_z_r <= res_z_r;
          out_m_r <= res_m_r;
          out_s_r <= res_s_r;
        end
      end
      default: ;
    endcase
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.z_result    = out_z_r;
  assign out_bus.exact_match = out_m_r;
  assign out_bus.status      = out_s_r;

endmodule

// File: rtl/idi_checker.sv
// Port-level checks for the inverse-distance interpolator, bound to the top level.
// Depends on idi_pkg and inverse_distance_interpolator.
module idi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [idi_pkg::COORD_BITS-1:0] z_result,
  input logic                          exact_match,
  input logic [1:0]                    status
);

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accepted beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != idi_pkg::ST_OK |-> z_result == '0 && !exact_match)
    else $error("error beat with payload");

  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && exact_match |-> status == idi_pkg::ST_OK)
    else $error("match with bad status");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

endmodule

bind inverse_distance_interpolator idi_checker u_idi_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .z_result    (out_bus.z_result),
  .exact_match (out_bus.exact_match),
  .status      (out_bus.status)
);

// File: tb/inverse_distance_interpolator_test.sv
// Testbench for the inverse-distance interpolator: directed and random loads, queries and clears.
// Holds its own table and weighting predictor, and checks every result beat in order.
// Depends on idi_pkg, idi_in_if, idi_out_if and the interpolator RTL.
module inverse_distance_interpolator_test;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 40000000;
  localparam int CB          = idi_pkg::COORD_BITS;
  localparam int TB_TOL_BITS = idi_pkg::TOL_BITS;

  typedef struct packed {
    logic signed [CB-1:0] z;
    logic                 hit;
    idi_pkg::status_t     st;
  } answer_t;

  class idw_scoreboard;
    logic signed [CB-1:0]    px[TABLE_DEPTH];
    logic signed [CB-1:0]    py[TABLE_DEPTH];
    logic signed [CB-1:0]    pz[TABLE_DEPTH];
    int                      count;
    logic [TB_TOL_BITS-1:0]  tol;
    answer_t                 expected[$];
    int                      errors;

    function void reset_state();
      count = 0;
      tol = idi_pkg::TOL_RESET;
      errors = 0;
    endfunction

    function answer_t interpolate(logic signed [CB-1:0] qx,
                                  logic signed [CB-1:0] qy);
      answer_t     r;
      logic [63:0] ax, ay, inv, w, sumw, azv;
      logic [127:0] d2, pos, neg, mag, q, rem;
      logic [31:0] mant[TABLE_DEPTH];
      int          len[TABLE_DEPTH];
      int          lmin, sh;
      longint      diff;
      r = '{z: '0, hit: 1'b0, st: idi_pkg::ST_OK};
      lmin = 1000;
      for (int i = 0; i < count; i++) begin
        diff = longint'(px[i]) - longint'(qx);
        ax = diff < 0 ? -diff : diff;
        diff = longint'(py[i]) - longint'(qy);
        ay = diff < 0 ? -diff : diff;
        if ((ax < tol && ay < tol) || (ax == 0 && ay == 0)) begin
          r.z = pz[i];
          r.hit = 1'b1;
          return r;
        end
        d2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        len[i] = 0;
        for (int b = 127; b >= 0; b--)
          if (len[i] == 0 && d2[b]) len[i] = b + 1;
        if (len[i] <= 32) mant[i] = 32'(d2 << (32 - len[i]));
        else mant[i] = 32'(d2 >> (len[i] - 32));
        if (len[i] < lmin) lmin = len[i];
      end
      sumw = 0;
      pos = 0;
      neg = 0;
      for (int i = 0; i < count; i++) begin
        inv = (64'd1 << 62) / 64'(mant[i]);
        sh = idi_pkg::WSHIFT + 2 * (len[i] - lmin);
        w = sh >= 64 ? 64'd0 : (inv * inv) >> sh;
        azv = pz[i] < 0 ? -64'(longint'(pz[i])) : 64'(longint'(pz[i]));
        sumw += w;
        if (pz[i] < 0) neg += 128'(w) * 128'(azv);
        else pos += 128'(w) * 128'(azv);
      end
      if (sumw == 0) begin
        r.st = idi_pkg::ST_EMPTY;
        return r;
      end
      mag = pos >= neg ? pos - neg : neg - pos;
      q = mag / 128'(sumw);
      rem = mag % 128'(sumw);
      if (2 * rem >= 128'(sumw)) q++;
      if (pos < neg) begin
        if (q > 128'h8000_0000) q = 128'h8000_0000;
        r.z = -32'(q);
      end else begin
        if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        r.z = 32'(q);
      end
      return r;
    endfunction

    function void note_input(idi_pkg::op_t op, logic signed [CB-1:0] x,
                             logic signed [CB-1:0] y,
                             logic signed [CB-1:0] z);
      answer_t r;
      r = '{z: '0, hit: 1'b0, st: idi_pkg::ST_OK};
      case (op)
        idi_pkg::OP_LOAD: begin
          if (count >= TABLE_DEPTH) r.st = idi_pkg::ST_FULL;
          else begin
            px[count] = x;
            py[count] = y;
            pz[count] = z;
            count++;
          end
        end
        idi_pkg::OP_CLEAR: count = 0;
        idi_pkg::OP_QUERY: begin
          if (count == 0) r.st = idi_pkg::ST_EMPTY;
          else r = interpolate(x, y);
        end
        default: ;
      endcase
      expected.insert(expected.size(), r);
    endfunction

    function void check_result(logic signed [CB-1:0] z, logic hit, logic [1:0] st);
      answer_t e;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: z=%h match=%b st=%0d", z, hit, st);
        return;
      end
      e = expected.pop_front();
      if (z !== e.z || hit !== e.hit || st !== e.st) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: z exp %h got %h, match exp %b got %b, st exp %0d got %0d",
                   e.z, z, e.hit, hit, e.st, st);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TB_TOL_BITS-1:0] cfg_wdata;
  int cycles;
  int burst_left;
  int items;
  idw_scoreboard sb;

  idi_in_if  in_ch();
  idi_out_if out_ch();

  inverse_distance_interpolator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: rotates among four stall patterns, from always ready to mostly stalled
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.z_result, out_ch.exact_match, out_ch.status);
    case ((cycles / 300) % 4)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 9) < 7;
      2: out_ch.ready <= (cycles % 37) < 20;
      default: out_ch.ready <= $urandom_range(0, 3) == 0;
    endcase
  end

  task automatic send_beat(idi_pkg::op_t op, logic signed [CB-1:0] x,
                           logic signed [CB-1:0] y,
                           logic signed [CB-1:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    in_ch.coord_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(op, x, y, z);
    burst_left--;
    if (op != idi_pkg::OP_NONE) items++;
  endtask

  task automatic settle();
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TB_TOL_BITS-1:0] v);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    settle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.tol = v;
  endtask

  function automatic logic signed [CB-1:0] any_coord();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return int'($urandom_range(0, 2097152)) - 1048576;
  endfunction

  task automatic run_phase();
    int n, k, j;
    logic signed [CB-1:0] qx, qy;
    if ($urandom_range(0, 4) != 0)
      send_beat(idi_pkg::OP_CLEAR, any_coord(), any_coord(), any_coord());
    n = $urandom_range(0, 19) == 0 ? $urandom_range(60, 70) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_beat(idi_pkg::OP_NONE, any_coord(), any_coord(), any_coord());
      send_beat(idi_pkg::OP_LOAD, any_coord(), any_coord(), any_coord());
    end
    k = $urandom_range(1, 4);
    for (int i = 0; i < k; i++) begin
      j = sb.count > 0 ? $urandom_range(0, sb.count - 1) : 0;
      qx = any_coord();
      qy = any_coord();
      case ($urandom_range(0, 3))
        0: begin qx = sb.px[j]; qy = sb.py[j]; end
        1: begin
          qx = sb.px[j] + (int'($urandom_range(0, 40000)) - 20000);
          qy = sb.py[j] + (int'($urandom_range(0, 40000)) - 20000);
        end
        default: ;
      endcase
      if (sb.count == 0) begin qx = any_coord(); qy = any_coord(); end
      send_beat(idi_pkg::OP_QUERY, qx, qy, any_coord());
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    cycles = 0;
    burst_left = 0;
    items = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = idi_pkg::OP_NONE;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty query, extremes, exact and near matches, overflow, unused op
    send_beat(idi_pkg::OP_QUERY, 32'sd0, 32'sd0, 32'sd0);
    send_beat(idi_pkg::OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_beat(idi_pkg::OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(idi_pkg::OP_LOAD, 32'sd65536, 32'sd65536, -32'sd1);
    send_beat(idi_pkg::OP_QUERY, 32'sd65536 + 32'sd100, 32'sd65536 - 32'sd100, 32'sd0);
    send_beat(idi_pkg::OP_QUERY, 32'sd0, 32'sd0, 32'sd0);
    send_beat(idi_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_beat(idi_pkg::OP_QUERY, 32'h8000_0000, 32'h8000_0000, 32'sd0);
    send_beat(idi_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(idi_pkg::OP_CLEAR, 32'sd0, 32'sd0, 32'sd0);
    send_beat(idi_pkg::OP_QUERY, 32'sd5, 32'sd5, 32'sd0);
    for (int i = 0; i < TABLE_DEPTH + 2; i++)
      send_beat(idi_pkg::OP_LOAD, any_coord(), any_coord(), $urandom);
    send_beat(idi_pkg::OP_QUERY, 32'sd0, 32'sd0, 32'sd0);
    write_tolerance('0);
    send_beat(idi_pkg::OP_QUERY, sb.px[3], sb.py[3], 32'sd0);
    send_beat(idi_pkg::OP_QUERY, sb.px[3] + 32'sd1, sb.py[3], 32'sd0);
    write_tolerance(31'h7FFF_FFFF);
    send_beat(idi_pkg::OP_QUERY, 32'sd0, 32'sd0, 32'sd0);
    send_beat(idi_pkg::OP_CLEAR, 32'sd0, 32'sd0, 32'sd0);

    while (items < 1650) begin
      if ($urandom_range(0, 9) == 0)
        case ($urandom_range(0, 4))
          0: write_tolerance('0);
          1: write_tolerance(idi_pkg::TOL_RESET);
          2: write_tolerance(31'h7FFF_FFFF);
          3: write_tolerance(31'($urandom_range(0, 200000)));
          default: write_tolerance(31'($urandom));
        endcase
      run_phase();
    end
    in_ch.valid <= 1'b0;
    settle();
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
